// ===== hdl/bdlp_pkg.sv =====
// Shared types, widths, codes and reset values for the two-button debouncer.
package bdlp_pkg;

    localparam int NOW_WIDTH      = 32;
    localparam int CFG_WIDTH      = 16;
    localparam int CFG_IDX_WIDTH  = 1;
    localparam int EVT_WIDTH      = 2;
    localparam int NUM_LANES      = 2;
    localparam int TIME_WIDTH_DEF = 32;

    // register indexes on the config port
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_IDX_DEBOUNCE   = 1'b0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_IDX_LONG_PRESS = 1'b1;

    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET   = 16'd50;
    localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET = 16'd1000;

    // button event codes
    localparam logic [EVT_WIDTH-1:0] EV_NONE  = 2'd0;
    localparam logic [EVT_WIDTH-1:0] EV_SHORT = 2'd1;
    localparam logic [EVT_WIDTH-1:0] EV_LONG  = 2'd2;

    typedef logic [EVT_WIDTH-1:0] t_evt;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] debounce_ms;
        logic [CFG_WIDTH-1:0] long_press_ms;
    } t_cfg;

endpackage

// ===== hdl/bdlp_lane.sv =====
// Per-button lane: debounce, press timing, pending event slot and consume.
module bdlp_lane #(
    parameter int TIME_WIDTH = bdlp_pkg::TIME_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  logic [TIME_WIDTH-1:0] i_now,
    input  logic                  i_raw_down,
    input  logic                  i_consume,
    input  bdlp_pkg::t_cfg        i_cfg,
    output bdlp_pkg::t_evt        o_evt
);
    import bdlp_pkg::*;

    logic                  r_stable_down,  n_stable_down;
    logic                  r_last_raw,     n_last_raw;
    logic [TIME_WIDTH-1:0] r_last_change,  n_last_change;
    logic [TIME_WIDTH-1:0] r_press_start,  n_press_start;
    logic                  r_long_fired,   n_long_fired;
    t_evt                  r_pending,      n_pending;

    t_evt                  w_pending_poll;
    logic [TIME_WIDTH-1:0] w_el_db;
    logic [TIME_WIDTH-1:0] w_el_press;
    logic                  w_settled;
    logic                  w_long;

    always_comb begin
        n_last_raw    = i_raw_down;
        n_last_change = (i_raw_down != r_last_raw) ? i_now : r_last_change;
        // wrapped differences
        w_el_db       = i_now - n_last_change;
        w_el_press    = i_now - r_press_start;
        w_settled     = w_el_db >= TIME_WIDTH'(i_cfg.debounce_ms);
        w_long        = w_el_press >= TIME_WIDTH'(i_cfg.long_press_ms);

        n_stable_down  = r_stable_down;
        n_press_start  = r_press_start;
        n_long_fired   = r_long_fired;
        w_pending_poll = r_pending;

        if (w_settled) begin
            if (i_raw_down && !r_stable_down) begin
                n_stable_down = 1'b1;
                n_press_start = i_now;
                n_long_fired  = 1'b0;
            end else if (!i_raw_down && r_stable_down) begin
                n_stable_down = 1'b0;
                if (!r_long_fired) begin
                    w_pending_poll = w_long ? EV_LONG : EV_SHORT;
                end
            end else if (i_raw_down && r_stable_down && !r_long_fired && w_long) begin
                n_long_fired   = 1'b1;
                w_pending_poll = EV_LONG;
            end
        end

        // consume reads the slot after this poll
        o_evt     = i_consume ? w_pending_poll : EV_NONE;
        n_pending = i_consume ? EV_NONE : w_pending_poll;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable_down <= 1'b0;
            r_last_raw    <= 1'b0;
            r_last_change <= '0;
            r_press_start <= '0;
            r_long_fired  <= 1'b0;
            r_pending     <= EV_NONE;
        end else if (i_fire) begin
            r_stable_down <= n_stable_down;
            r_last_raw    <= n_last_raw;
            r_last_change <= n_last_change;
            r_press_start <= n_press_start;
            r_long_fired  <= n_long_fired;
            r_pending     <= n_pending;
        end
    end

    a_consume_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_consume |=> r_pending == EV_NONE)
        else $error("pending slot not cleared after consume");

    a_state_holds_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_stable_down) && $stable(r_pending) && $stable(r_long_fired))
        else $error("lane state moved without a poll");

    a_slot_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending == EV_NONE || r_pending == EV_SHORT || r_pending == EV_LONG)
        else $error("pending slot holds an unused code");

endmodule

// ===== hdl/bdlp_out_reg.sv =====
// Merge stage: gathers both lane events into the registered result item.
module bdlp_out_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  bdlp_pkg::t_evt i_tare_evt,
    input  bdlp_pkg::t_evt i_run_evt,
    input  logic           i_out_ready,
    output logic           o_load_ok,
    output logic           o_out_valid,
    output bdlp_pkg::t_evt o_tare_event,
    output bdlp_pkg::t_evt o_run_event
);
    import bdlp_pkg::*;

    logic r_valid;
    t_evt r_tare;
    t_evt r_run;

    // a new item may enter when the slot is empty or drains this cycle
    assign o_load_ok    = !r_valid || i_out_ready;
    assign o_out_valid  = r_valid;
    assign o_tare_event = r_tare;
    assign o_run_event  = r_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_tare <= i_tare_evt;
            r_run  <= i_run_evt;
        end
    end

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> r_valid && r_tare == $past(i_tare_evt) && r_run == $past(i_run_evt))
        else $error("loaded item not presented");

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_load_ok)
        else $error("result overwritten while stalled");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid && !i_load |=> !r_valid)
        else $error("result appeared without a poll");

endmodule

// ===== hdl/button_debounce_long_press.sv =====
// Top level of the two-button debouncer with short and long press events.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready): one poll item per handshake, carrying
//   a millisecond timestamp, the raw active-low tare and run pin levels and one
//   consume flag per button.
//   Output channel (o_out_valid / i_out_ready): exactly one result item per poll,
//   the consumed tare and run events (0 none, 1 short, 2 long).
//   Config port: i_cfg_we writes i_cfg_data into register i_cfg_idx
//   (0 debounce_ms, 1 long_press_ms) at the clock edge; write only while idle.
// Timing and throughput:
//   The result of a poll is visible in the cycle after the item is taken. Both
//   lanes update their state in the accepting cycle, so one poll per cycle is
//   sustained while i_out_ready is high; the single output register sets that figure.
// Reset (synchronous, i_rst_n low): all button state and pending slots clear,
//   debounce_ms returns to 50 and long_press_ms to 1000; no result is held.
// Stall: while i_out_ready is low the result holds and o_in_ready stays high
//   only if the output register is empty or drains in the same cycle.
module button_debounce_long_press #(
    parameter int TIME_WIDTH = bdlp_pkg::TIME_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // config write port
    input  logic                                 i_cfg_we,
    input  logic [bdlp_pkg::CFG_IDX_WIDTH-1:0]   i_cfg_idx,
    input  logic [bdlp_pkg::CFG_WIDTH-1:0]       i_cfg_data,
    // poll items in
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [bdlp_pkg::NOW_WIDTH-1:0]       i_now_ms,
    input  logic                                 i_tare_pin_level,
    input  logic                                 i_run_pin_level,
    input  logic                                 i_consume_tare,
    input  logic                                 i_consume_run,
    // result items out
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [bdlp_pkg::EVT_WIDTH-1:0]       o_tare_event,
    output logic [bdlp_pkg::EVT_WIDTH-1:0]       o_run_event
);
    import bdlp_pkg::*;

    t_cfg                  r_cfg;
    logic                  w_fire;
    logic [TIME_WIDTH-1:0] w_now;
    logic [NUM_LANES-1:0]  w_raw_down;
    logic [NUM_LANES-1:0]  w_consume;
    t_evt                  w_evt [NUM_LANES];

    // --- config registers ---
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms   <= DEBOUNCE_RESET;
            r_cfg.long_press_ms <= LONG_PRESS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IDX_DEBOUNCE:   r_cfg.debounce_ms   <= i_cfg_data;
                CFG_IDX_LONG_PRESS: r_cfg.long_press_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // --- poll handshake ---
    assign w_fire = i_in_valid && o_in_ready;

    // time kept modulo 2^TIME_WIDTH: truncate or zero-extend the stamp
    assign w_now = TIME_WIDTH'(i_now_ms);

    // lane 0 is tare, lane 1 is run; pins are active low
    assign w_raw_down = {~i_run_pin_level, ~i_tare_pin_level};
    assign w_consume  = {i_consume_run, i_consume_tare};

    // --- one lane per button, independent of each other ---
    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        bdlp_lane #(
            .TIME_WIDTH (TIME_WIDTH)
        ) u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_fire     (w_fire),
            .i_now      (w_now),
            .i_raw_down (w_raw_down[g]),
            .i_consume  (w_consume[g]),
            .i_cfg      (r_cfg),
            .o_evt      (w_evt[g])
        );
    end

    // --- merge both lanes into the result register ---
    bdlp_out_reg u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_fire),
        .i_tare_evt   (w_evt[0]),
        .i_run_evt    (w_evt[1]),
        .i_out_ready  (i_out_ready),
        .o_load_ok    (o_in_ready),
        .o_out_valid  (o_out_valid),
        .o_tare_event (o_tare_event),
        .o_run_event  (o_run_event)
    );

    a_no_consume_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && !i_consume_tare && !i_consume_run |=>
            o_tare_event == EV_NONE && o_run_event == EV_NONE)
        else $error("event reported without consume");

    a_cfg_debounce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && i_cfg_idx == CFG_IDX_DEBOUNCE |=> r_cfg.debounce_ms == $past(i_cfg_data))
        else $error("debounce register write lost");

    a_cfg_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && i_cfg_idx == CFG_IDX_LONG_PRESS |=>
            r_cfg.long_press_ms == $past(i_cfg_data))
        else $error("long press register write lost");

endmodule
